FILE: hdl/command_line_beacon_frame_builder_core_defines.svh
// Assertion macros for the beacon frame builder core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef COMMAND_LINE_BEACON_FRAME_BUILDER_CORE_DEFINES_SVH
`define COMMAND_LINE_BEACON_FRAME_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cbf_pkg.sv
// Shared constants and codes for the beacon frame builder.
// No dependencies.
`default_nettype none
package cbf_pkg;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int MAX_SSID   = 32;

  localparam logic [2:0] K_HANDSHAKE = 3'd0;
  localparam logic [2:0] K_OK        = 3'd1;
  localparam logic [2:0] K_FRAME     = 3'd2;
  localparam logic [2:0] K_MALFORMED = 3'd3;
  localparam logic [2:0] K_INJ_OFF   = 3'd4;
  localparam logic [2:0] K_BAD_BSSID = 3'd5;
  localparam logic [2:0] K_BAD_SSID  = 3'd6;
  localparam logic [2:0] K_UNKNOWN   = 3'd7;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
endpackage
`default_nettype wire

FILE: hdl/cbf_line_ram.sv
// Line buffer: one write port, one read port with registered data.
// Depends on cbf_pkg.
`default_nettype none
module cbf_line_ram
  import cbf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata_r
);
  logic [7:0] mem [LINE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/command_line_beacon_frame_builder_core.sv
// Line byte: stored if room, no result. Newline: a CR check, a scan of each
// stored byte to parse, then one status beat or a frame of up to 83 bytes,
// up to two bytes per beat, read via the single read port of the line buffer.
// Next byte is taken once the last result is registered. Synchronous active-low
// reset clears line length, injection flag, output valid; channel resets to 6.
`default_nettype none
`include "command_line_beacon_frame_builder_core_defines.svh"
module command_line_beacon_frame_builder_core
  import cbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [2:0]  out_kind,
  output logic      [15:0] out_frame_bytes,
  output logic      [1:0]  out_byte_count,
  output logic             out_last,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data
);
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CR     = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FETCH  = 3'd4;
  localparam logic [2:0] ST_BYTE   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              inj_r, inj_nxt;
  logic [3:0]        chan_r;
  logic [7:0]        b_r [5];
  logic [7:0]        b_nxt [5];
  logic [47:0]       mac_r, mac_nxt;
  logic              hexok_r, hexok_nxt;
  logic              sp_r, sp_nxt;
  logic [6:0]        j_r, j_nxt;
  logic [7:0]        hi_r, hi_nxt;

  logic              out_valid_r;
  logic [2:0]        out_kind_r;
  logic [15:0]       out_fb_r;
  logic [1:0]        out_cnt_r;
  logic              out_last_r;
  logic              ld;
  logic [2:0]        ld_kind;
  logic [15:0]       ld_fb;
  logic [1:0]        ld_cnt;
  logic              ld_last;

  logic              acc, out_free, we;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic [4:0]        hexv;
  logic [6:0]        ssid_cnt, frm_total, tail;
  logic [7:0]        fb;

  cbf_line_ram u_ram (
    .clk(clk), .we(we), .waddr(len_r), .wdata(in_rx_byte),
    .raddr(raddr), .rdata_r(rdata)
  );

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b1, c[3:0] + 4'd9};
    return v;
  endfunction

  function automatic logic [7:0] mac_byte(input logic [47:0] m, input logic [2:0] k);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      3'd0: r = m[47:40];
      3'd1: r = m[39:32];
      3'd2: r = m[31:24];
      3'd3: r = m[23:16];
      3'd4: r = m[15:8];
      3'd5: r = m[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [6:0] t, input logic [3:0] ch);
    logic [7:0] r;
    r = 8'h00;
    unique case (t)
      7'd0:  r = 8'h01;
      7'd1:  r = 8'h08;
      7'd2:  r = 8'h82;
      7'd3:  r = 8'h84;
      7'd4:  r = 8'h8B;
      7'd5:  r = 8'h96;
      7'd6:  r = 8'h24;
      7'd7:  r = 8'h30;
      7'd8:  r = 8'h48;
      7'd9:  r = 8'h6C;
      7'd10: r = 8'h03;
      7'd11: r = 8'h01;
      7'd12: r = {4'h0, ch};
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign we       = acc && (in_rx_byte != CH_LF) && (len_r != ADDR_W'(LINE_BYTES - 1));
  assign hexv     = hex_val(rdata);
  assign ssid_cnt = 7'(len_r) - 7'd17;
  assign frm_total = ssid_cnt + 7'd51;
  assign tail     = j_r - 7'd38 - ssid_cnt;

  always_comb begin
    unique case (state_r)
      ST_IDLE: raddr = len_r - 1'b1;
      ST_CR:   raddr = '0;
      ST_SCAN: raddr = idx_r + 1'b1;
      default: raddr = ADDR_W'(j_r - 7'd21);
    endcase
  end

  // frame byte at position j_r
  always_comb begin
    if (j_r == 7'd0)       fb = 8'h80;
    else if (j_r < 7'd4)   fb = 8'h00;
    else if (j_r < 7'd10)  fb = 8'hFF;
    else if (j_r < 7'd16)  fb = mac_byte(mac_r, 3'(j_r - 7'd10));
    else if (j_r < 7'd22)  fb = mac_byte(mac_r, 3'(j_r - 7'd16));
    else if (j_r == 7'd32) fb = 8'h64;
    else if (j_r == 7'd34) fb = 8'h31;
    else if (j_r == 7'd35) fb = 8'h04;
    else if (j_r < 7'd37)  fb = 8'h00;
    else if (j_r == 7'd37) fb = {1'b0, ssid_cnt};
    else if (j_r < 7'd38 + ssid_cnt) fb = rdata;
    else                   fb = tail_byte(tail, chan_r);
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    inj_nxt   = inj_r;
    b_nxt     = b_r;
    mac_nxt   = mac_r;
    hexok_nxt = hexok_r;
    sp_nxt    = sp_r;
    j_nxt     = j_r;
    hi_nxt    = hi_r;
    ld        = 1'b0;
    ld_kind   = K_OK;
    ld_fb     = 16'h0000;
    ld_cnt    = 2'd0;
    ld_last   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_rx_byte != CH_LF) begin
            if (we) len_nxt = len_r + 1'b1;
          end else if (len_r != '0) begin
            state_nxt = ST_CR;
          end
        end
      end
      ST_CR: begin
        if (rdata == CH_CR) len_nxt = len_r - 1'b1;
        if (len_nxt == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = '0;
          hexok_nxt = 1'b1;
          sp_nxt    = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r < ADDR_W'(5)) b_nxt[3'(idx_r)] = rdata;
        if (idx_r >= ADDR_W'(4) && idx_r <= ADDR_W'(15)) begin
          hexok_nxt = hexok_r & hexv[4];
          mac_nxt   = {mac_r[43:0], hexv[3:0]};
        end
        if (idx_r == ADDR_W'(16)) sp_nxt = (rdata == CH_SPACE);
        if (idx_r == len_r - 1'b1) state_nxt = ST_DECIDE;
        idx_nxt = idx_r + 1'b1;
      end
      ST_DECIDE: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
          len_nxt   = '0;
          if (len_r == ADDR_W'(3) && b_r[0] == "F" && b_r[1] == "F" && b_r[2] == "?") begin
            ld_kind = K_HANDSHAKE;
          end else if (len_r == ADDR_W'(4) && b_r[0] == "F" && b_r[1] == "F"
                       && b_r[2] == "O" && b_r[3] == "N") begin
            inj_nxt = 1'b1;
          end else if (len_r == ADDR_W'(5) && b_r[0] == "F" && b_r[1] == "F"
                       && b_r[2] == "O" && b_r[3] == "F" && b_r[4] == "F") begin
            inj_nxt = 1'b0;
          end else if (len_r >= ADDR_W'(4) && b_r[0] == "F" && b_r[1] == "F"
                       && b_r[2] == "B" && b_r[3] == CH_SPACE) begin
            if (len_r < ADDR_W'(18) || !sp_r) ld_kind = K_MALFORMED;
            else if (!inj_r)                  ld_kind = K_INJ_OFF;
            else if (!hexok_r)                ld_kind = K_BAD_BSSID;
            else if (ssid_cnt > 7'(MAX_SSID)) ld_kind = K_BAD_SSID;
            else begin
              ld        = 1'b0;
              len_nxt   = len_r;
              j_nxt     = '0;
              state_nxt = ST_FETCH;
            end
          end else begin
            ld_kind = K_UNKNOWN;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_BYTE;
      end
      ST_BYTE: begin
        ld_kind = K_FRAME;
        ld_last = (j_r == frm_total - 1'b1);
        if (!j_r[0] && !ld_last) begin
          hi_nxt    = fb;
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_FETCH;
        end else if (out_free) begin
          ld = 1'b1;
          if (j_r[0]) begin
            ld_fb  = {hi_r, fb};
            ld_cnt = 2'd2;
          end else begin
            ld_fb  = {fb, 8'h00};
            ld_cnt = 2'd1;
          end
          j_nxt = j_r + 1'b1;
          if (ld_last) begin
            len_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      inj_r       <= 1'b0;
      chan_r      <= 4'd6;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      inj_r   <= inj_nxt;
      if (cfg_wr_en) chan_r <= cfg_wr_data;
      if (ld) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    b_r     <= b_nxt;
    mac_r   <= mac_nxt;
    hexok_r <= hexok_nxt;
    sp_r    <= sp_nxt;
    j_r     <= j_nxt;
    hi_r    <= hi_nxt;
    if (ld) begin
      out_kind_r <= ld_kind;
      out_fb_r   <= ld_fb;
      out_cnt_r  <= ld_cnt;
      out_last_r <= ld_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_frame_bytes = out_fb_r;
  assign out_byte_count  = out_cnt_r;
  assign out_last        = out_last_r;

  `CBF_ASSERT_NOW(a_cnt_kind, out_valid, (out_byte_count != 2'd0) == (out_kind == K_FRAME), "byte count disagrees with kind")
  `CBF_ASSERT_NOW(a_status_last, out_valid && out_kind != K_FRAME, out_last && out_frame_bytes == 16'h0000, "status beat malformed")
  `CBF_ASSERT_NEXT(a_lf_busy, in_valid && !in_stall && in_rx_byte == CH_LF && len_r != '0, in_stall, "newline not processed")
endmodule
`default_nettype wire

FILE: dv/command_line_beacon_frame_builder_core_tb.sv
// Self-checking testbench for command_line_beacon_frame_builder_core.
// Drives serial bytes and checks frame and status beats against a local predictor.
// Depends on cbf_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module command_line_beacon_frame_builder_core_tb;
  import cbf_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] fbytes;
    logic [1:0]  count;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [15:0] out_frame_bytes;
  logic [1:0] out_byte_count;
  logic out_last;
  logic cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = 4'd0;

  command_line_beacon_frame_builder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_frame_bytes(out_frame_bytes), .out_byte_count(out_byte_count),
    .out_last(out_last), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0] exp_line [LINE_BYTES];
  int unsigned line_len;
  logic inj_on;
  logic [3:0] chan_reg;
  beat_t beats_due[$];
  int errors;
  int send_idle_pct, recv_stall_pct;
  int hold_cycles;
  longint cycle_cnt;

  function automatic int hexval(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit line_matches(string s);
    if (line_len != s.len()) return 0;
    for (int i = 0; i < s.len(); i++)
      if (exp_line[i] != s[i]) return 0;
    return 1;
  endfunction

  function automatic void push_status(logic [2:0] k);
    beat_t b;
    b.kind = k; b.fbytes = 16'd0; b.count = 2'd0; b.last = 1'b1;
    beats_due.push_back(b);
  endfunction

  function automatic void predict_beacon();
    logic [7:0] frm[$];
    logic [7:0] mac[6];
    logic [7:0] tail[24];
    int hv, lv, slen, n;
    beat_t b;
    tail = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
             8'h64, 8'h00, 8'h31, 8'h04, 8'h01, 8'h08, 8'h82, 8'h84, 8'h8B, 8'h96,
             8'h24, 8'h30, 8'h48, 8'h6C};
    if (line_len < 18 || exp_line[16] != CH_SPACE) begin
      push_status(K_MALFORMED);
      return;
    end
    if (!inj_on) begin
      push_status(K_INJ_OFF);
      return;
    end
    for (int i = 0; i < 6; i++) begin
      hv = hexval(exp_line[4 + 2 * i]);
      lv = hexval(exp_line[5 + 2 * i]);
      if (hv < 0 || lv < 0) begin
        push_status(K_BAD_BSSID);
        return;
      end
      mac[i] = 8'((hv << 4) | lv);
    end
    slen = line_len - 17;
    if (slen == 0 || slen > MAX_SSID) begin
      push_status(K_BAD_SSID);
      return;
    end
    frm = '{8'h80, 8'h00, 8'h00, 8'h00};
    repeat (6) frm.push_back(8'hFF);
    for (int r = 0; r < 2; r++)
      for (int i = 0; i < 6; i++) frm.push_back(mac[i]);
    for (int i = 0; i < 14; i++) frm.push_back(tail[i]);
    frm.push_back(8'h00);
    frm.push_back(8'(slen));
    for (int i = 0; i < slen; i++) frm.push_back(exp_line[17 + i]);
    for (int i = 14; i < 24; i++) frm.push_back(tail[i]);
    frm.push_back(8'h03);
    frm.push_back(8'h01);
    frm.push_back({4'd0, chan_reg});
    n = (frm.size() + 1) / 2;
    for (int k = 0; k < n; k++) begin
      b.kind = K_FRAME;
      if (2 * k + 1 < frm.size()) begin
        b.fbytes = {frm[2 * k], frm[2 * k + 1]};
        b.count = 2'd2;
      end else begin
        b.fbytes = {frm[2 * k], 8'h00};
        b.count = 2'd1;
      end
      b.last = (k + 1 == n);
      beats_due.push_back(b);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] c);
    if (c != CH_LF) begin
      if (line_len < LINE_BYTES - 1) begin
        exp_line[line_len] = c;
        line_len++;
      end
      return;
    end
    if (line_len > 0 && exp_line[line_len - 1] == CH_CR) line_len--;
    if (line_len > 0) begin
      if (line_matches("FF?")) push_status(K_HANDSHAKE);
      else if (line_matches("FFON")) begin
        inj_on = 1'b1;
        push_status(K_OK);
      end else if (line_matches("FFOFF")) begin
        inj_on = 1'b0;
        push_status(K_OK);
      end else if (line_len >= 4 && exp_line[0] == "F" && exp_line[1] == "F" &&
                   exp_line[2] == "B" && exp_line[3] == CH_SPACE)
        predict_beacon();
      else push_status(K_UNKNOWN);
    end
    line_len = 0;
  endfunction

  // result checker
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat kind=%0d", out_kind);
        errors++;
      end else begin
        e = beats_due.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind);
          errors++;
        end
        if (out_frame_bytes !== e.fbytes) begin
          $error("frame_bytes: expected %h, got %h", e.fbytes, out_frame_bytes);
          errors++;
        end
        if (out_byte_count !== e.count) begin
          $error("byte_count: expected %0d, got %0d", e.count, out_byte_count);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else
      out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // valid stays high after the accepting edge; the next call reloads or drops it, drain() drops it
  task automatic send_byte(logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(c);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_LF);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_channel(logic [3:0] ch);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ch;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chan_reg = ch;
  endtask

  function automatic string rand_hex(int n, bit allow_bad);
    string s, digits;
    s = "";
    digits = "0123456789abcdefABCDEF";
    for (int i = 0; i < n; i++) begin
      s = {s, " "};
      if (allow_bad && $urandom_range(7) == 0) s[i] = 8'($urandom_range(255));
      else s[i] = digits[$urandom_range(21)];
      if (s[i] == CH_LF) s[i] = "g";
    end
    return s;
  endfunction

  function automatic string rand_ssid(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) begin
      s = {s, " "};
      s[i] = 8'($urandom_range(255));
      if (s[i] == CH_LF) s[i] = 8'hFF;
    end
    return s;
  endfunction

  // directed table: line text plus the status expected where obvious
  // (kind K_FRAME here means "check against predictor only")
  typedef struct {
    string txt;
    logic [2:0] kind;
  } row_t;
  row_t dir_rows[$];

  task automatic random_item();
    int sel;
    string s;
    sel = $urandom_range(99);
    if (sel < 55) begin
      s = {"FFB ", rand_hex(12, 1), " ", rand_ssid($urandom_range(1, 34))};
      if ($urandom_range(9) == 0) s = {s, "\015"};
      send_line(s);
    end else if (sel < 65) send_line("FFON");
    else if (sel < 70) send_line("FFOFF");
    else if (sel < 75) send_line("FF?");
    else if (sel < 80) send_line({"FFB ", rand_hex(12, 0), rand_ssid($urandom_range(0, 4))});
    else if (sel < 95) send_line(rand_ssid($urandom_range(0, 20)));
    else send_byte(CH_LF);
  endtask

  initial begin
    string s;
    errors = 0;
    line_len = 0;
    inj_on = 1'b0;
    chan_reg = 4'd6;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    cycle_cnt = 0;
    foreach (exp_line[i]) exp_line[i] = 8'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    s = "";
    for (int i = 0; i < 64; i++) s = {s, "Z"};
    dir_rows = '{
      '{"FF?", K_HANDSHAKE}, '{"FF?\015", K_HANDSHAKE}, '{"", K_FRAME}, '{"\015", K_FRAME},
      '{"FFB 0123456789ab x", K_INJ_OFF}, '{"FFB 01", K_MALFORMED},
      '{"FFOFF", K_OK}, '{"FFON", K_OK}, '{"FFB 0123456789abx", K_MALFORMED},
      '{"FFB 0123456789aG x", K_BAD_BSSID},
      '{"FFB 0123456789ab 123456789012345678901234567890123", K_BAD_SSID},
      '{"FFB 0123456789AB x", K_FRAME}, '{"FFB ffFFffFFffFF ab", K_FRAME},
      '{"FFB 000000000000 12345678901234567890123456789012", K_FRAME},
      '{"ff?", K_UNKNOWN}, '{"FF?x", K_UNKNOWN}, '{s, K_UNKNOWN}, '{"FFOFF", K_OK}
    };
    foreach (dir_rows[r]) begin
      send_line(dir_rows[r].txt);
      if (dir_rows[r].kind != K_FRAME && beats_due.size() != 0 &&
          beats_due[beats_due.size() - 1].kind != dir_rows[r].kind) begin
        $error("directed kind: expected %0d, got %0d", dir_rows[r].kind,
               beats_due[beats_due.size() - 1].kind);
        errors++;
      end
    end
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_line("FFON");

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; set_channel(4'd1); end
        1: begin send_idle_pct = 51; recv_stall_pct = 0; set_channel(4'd14); end
        2: begin send_idle_pct = 0; recv_stall_pct = 51; set_channel(4'd0); end
        3: begin send_idle_pct = 7; recv_stall_pct = 7; set_channel(4'd15); end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; set_channel(4'd9); end
      endcase
      if (ph == 4) begin
        // long receiver hold-off while beacons keep coming
        hold_cycles = 3000;
        send_line("FFON");
        send_line({"FFB ", rand_hex(12, 0), " ", rand_ssid(32)});
      end
      for (int i = 0; i < 2; i++) random_item();
      drain();  // sender pause until all results are back
    end
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
